// ===== rtl/drt_pkg.sv =====
// ============================================================================
// drt_pkg - shared types and constants of the dirty range tracker
// Table depth, entry and token records that travel along the cell chain.
// ============================================================================
`default_nettype none

package drt_pkg;

  localparam int TABLE_DEPTH = 16;

  localparam int OFF_W  = 16;
  localparam int SIZE_W = 16;
  localparam int MSIZE_W = 17;

  // Wait counter of the record pass: counts the cycles after cell 0.
  localparam int CNT_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH - 1) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 2);

  // One held range.
  typedef struct packed {
    logic              vld;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // A range that walks down the chain looking for its slot.
  typedef struct packed {
    logic              vld;
    logic              ins;   // may take a free or displaced slot
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/drt_in_if.sv =====
// ============================================================================
// drt_in_if - input channel of the dirty range tracker
// Valid/ready channel carrying one record or flush item.
// ============================================================================
`default_nettype none

interface drt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] range_offset;
  logic [15:0] range_size;

  modport source (output valid, output action, output range_offset,
                  output range_size, input ready);
  modport sink   (input valid, input action, input range_offset,
                  input range_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/drt_out_if.sv =====
// ============================================================================
// drt_out_if - result channel of the dirty range tracker
// Valid/ready channel carrying one merged range.
// ============================================================================
`default_nettype none

interface drt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] merged_offset;
  logic [16:0] merged_size;
  logic        is_empty;
  logic        is_last;

  modport source (output valid, output merged_offset, output merged_size,
                  output is_empty, output is_last, input ready);
  modport sink   (input valid, input merged_offset, input merged_size,
                  input is_empty, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/drt_cell.sv =====
// ============================================================================
// drt_cell - one slot of the sorted range chain
// Holds one entry; inserts, overwrites or forwards the passing token and
// shifts its entry toward the head during a flush.
// ============================================================================
`default_nettype none

module drt_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire drt_pkg::tok_t   tok_i,
  input  wire drt_pkg::entry_t nbr_i,
  output drt_pkg::tok_t        tok_o,
  output drt_pkg::entry_t      ent_o
);
  import drt_pkg::*;

  entry_t ent_q, ent_d;
  tok_t   tok_q, tok_d;

  always_comb begin
    ent_d = ent_q;
    tok_d = '0;
    if (shift_i) begin
      ent_d = nbr_i;
    end else if (tok_i.vld) begin
      if (ent_q.vld && ent_q.off == tok_i.off) begin
        // same offset: replace size, token ends here
        ent_d.size = tok_i.size;
      end else if (ent_q.vld && ent_q.off > tok_i.off && tok_i.ins) begin
        // take the token, push the old entry on
        ent_d = '{vld: 1'b1, off: tok_i.off, size: tok_i.size};
        tok_d = '{vld: 1'b1, ins: 1'b1, off: ent_q.off, size: ent_q.size};
      end else if (!ent_q.vld && tok_i.ins) begin
        ent_d = '{vld: 1'b1, off: tok_i.off, size: tok_i.size};
      end else begin
        tok_d = tok_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign ent_o = ent_q;

endmodule

`default_nettype wire

// ===== rtl/drt_merge.sv =====
// ============================================================================
// drt_merge - interval union at the head of the chain
// Folds sorted entries into merged ranges and drives the result register.
// ============================================================================
`default_nettype none

module drt_merge (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            active_i,
  input  wire drt_pkg::entry_t head_i,
  output logic                 adv_o,
  output logic                 done_o,
  drt_out_if.source            out_o
);
  import drt_pkg::*;

  logic               have_q, have_d;
  logic [OFF_W-1:0]   start_q, start_d;
  logic [MSIZE_W-1:0] end_q, end_d;
  logic               vld_q, vld_d;
  logic [OFF_W-1:0]   roff_q, roff_d;
  logic [MSIZE_W-1:0] rsize_q, rsize_d;
  logic               remp_q, remp_d;
  logic               rlast_q, rlast_d;

  logic               slot_free;
  logic [MSIZE_W-1:0] head_end;
  logic               gap;

  assign slot_free = !vld_q || out_o.ready;
  assign head_end  = MSIZE_W'(head_i.off) + MSIZE_W'(head_i.size);
  assign gap       = have_q && (MSIZE_W'(head_i.off) > end_q);

  always_comb begin
    have_d  = have_q;
    start_d = start_q;
    end_d   = end_q;
    vld_d   = vld_q && !out_o.ready;
    roff_d  = roff_q;
    rsize_d = rsize_q;
    remp_d  = remp_q;
    rlast_d = rlast_q;
    adv_o   = 1'b0;
    done_o  = 1'b0;
    if (active_i) begin
      if (!head_i.vld) begin
        // chain drained: close the flush
        if (slot_free) begin
          done_o  = 1'b1;
          vld_d   = 1'b1;
          roff_d  = have_q ? start_q : '0;
          rsize_d = have_q ? (end_q - MSIZE_W'(start_q)) : '0;
          remp_d  = !have_q;
          rlast_d = 1'b1;
          have_d  = 1'b0;
        end
      end else if (gap) begin
        if (slot_free) begin
          adv_o   = 1'b1;
          vld_d   = 1'b1;
          roff_d  = start_q;
          rsize_d = end_q - MSIZE_W'(start_q);
          remp_d  = 1'b0;
          rlast_d = 1'b0;
          start_d = head_i.off;
          end_d   = head_end;
        end
      end else begin
        adv_o  = 1'b1;
        have_d = 1'b1;
        if (!have_q) begin
          start_d = head_i.off;
          end_d   = head_end;
        end else if (head_end > end_q) begin
          end_d = head_end;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      have_q <= have_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    roff_q  <= roff_d;
    rsize_q <= rsize_d;
    remp_q  <= remp_d;
    rlast_q <= rlast_d;
  end

  assign out_o.valid         = vld_q;
  assign out_o.merged_offset = roff_q;
  assign out_o.merged_size   = rsize_q;
  assign out_o.is_empty      = remp_q;
  assign out_o.is_last       = rlast_q;

endmodule

`default_nettype wire

// ===== rtl/dirty_range_tracker_merge.sv =====
// ============================================================================
// dirty_range_tracker_merge - dirty byte range tracker with interval merge
// Sorted chain of range cells with a merge unit at its head.
// ============================================================================
//
// Ranges are held in a chain of TABLE_DEPTH cells kept sorted by offset.
// A record item enters cell 0 as a token that walks one cell per cycle: it
// overwrites the size of a cell with the same offset, takes the first free
// cell, or displaces a larger offset which walks on in its place. When the
// last cell is occupied the table is full and a new offset is dropped, but
// a matching offset still gets its size replaced. A record item holds off
// new items until its token has cleared the chain; it gives no result. A
// flush item shifts the chain toward the merge unit one entry per cycle,
// stalling while a finished union waits for the result channel; the merge
// unit folds overlapping or touching ranges and emits each union. A flush
// leaves the chain empty. A flush of an empty table gives one result with
// is_empty and is_last set. Results sit in an output register, so the next
// item is taken while the final result of a flush still waits.
// ============================================================================
`default_nettype none

module dirty_range_tracker_merge (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  drt_in_if.sink    in_i,
  drt_out_if.source out_o
);
  import drt_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RECORD = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  entry_t ent [TABLE_DEPTH+1];
  tok_t   tok [TABLE_DEPTH+1];

  logic in_acc;
  logic shift;
  logic done;
  logic full;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign full       = ent[TABLE_DEPTH-1].vld;

  // Inject a record token into the head cell on acceptance.
  assign tok[0] = '{vld:  in_acc && !in_i.action,
                    ins:  !full,
                    off:  in_i.range_offset,
                    size: in_i.range_size};

  // Nothing shifts in past the tail.
  assign ent[TABLE_DEPTH] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    drt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .tok_i   (tok[i]),
      .nbr_i   (ent[i+1]),
      .tok_o   (tok[i+1]),
      .ent_o   (ent[i])
    );
  end

  drt_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_i (state_q == ST_FLUSH),
    .head_i   (ent[0]),
    .adv_o    (shift),
    .done_o   (done),
    .out_o    (out_o)
  );

  // Sequencer: hold off new items while a token walks or a flush drains.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.action) begin
            state_d = ST_FLUSH;
          end else if (TABLE_DEPTH > 1) begin
            state_d = ST_RECORD;
            cnt_d   = '0;
          end
        end
      end
      ST_RECORD: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_FLUSH: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // The last cell's token only carries a dropped range; nothing reads it.
  logic unused_tail;
  assign unused_tail = ^tok[TABLE_DEPTH];

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ============================================================================
// testbench - self-checking bench of dirty_range_tracker_merge
// Drives record and flush items over the input channel and keeps its own
// table of held ranges. On every flush it sorts and folds that table into the
// merged ranges the block must emit. Each result is compared field by field
// with the oldest merged range still outstanding.
// ============================================================================
`default_nettype none

module testbench;
  import drt_pkg::*;

  // Action codes of the input item.
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  // Stop points of the random traffic, in accepted items.
  localparam int IDLE_PHASE_END = 340;
  localparam int ITEM_TOTAL     = 410;

  // The cycle limit sits far above the slowest correct run.
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;

  typedef struct packed {
    logic [OFF_W-1:0]   offset;
    logic [MSIZE_W-1:0] msize;
    logic               is_empty;
    logic               is_last;
  } merged_range_t;

  logic clk_i;
  logic rst_ni;

  drt_in_if  in_ch ();
  drt_out_if out_ch ();

  dirty_range_tracker_merge dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Ranges the block should hold, in arrival order.
  logic [OFF_W-1:0]  held_off[$];
  logic [SIZE_W-1:0] held_size[$];

  // Merged ranges still owed by the block, oldest first.
  merged_range_t merged_expected_q[$];

  int  mismatch_cnt = 0;
  int  items_sent   = 0;
  int  cycle_cnt    = 0;
  bit  idle_en      = 1'b1;
  bit  hold_off_req = 1'b0;

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("FAIL dirty_range_tracker_merge");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Range table model
  // --------------------------------------------------------------------------

  // Record: replace the size of a held offset, else append while there is room.
  function automatic void track_record(input logic [OFF_W-1:0] off,
                                       input logic [SIZE_W-1:0] sz);
    foreach (held_off[i]) begin
      if (held_off[i] == off) begin
        held_size[i] = sz;
        return;
      end
    end
    if (held_off.size() < TABLE_DEPTH) begin
      held_off.push_back(off);
      held_size.push_back(sz);
    end
  endfunction

  function automatic void push_merged(input int unsigned start_off,
                                      input int unsigned end_off,
                                      input logic empty_flag,
                                      input logic last_flag);
    merged_range_t r;
    r.offset   = OFF_W'(start_off);
    r.msize    = MSIZE_W'(end_off - start_off);
    r.is_empty = empty_flag;
    r.is_last  = last_flag;
    merged_expected_q.push_back(r);
  endfunction

  // Flush: sort held ranges by offset, fold overlapping or touching ones into
  // their union, queue one merged range per union and clear the table.
  function automatic void merge_flush();
    logic [OFF_W-1:0]  srt_off[$];
    logic [SIZE_W-1:0] srt_size[$];
    logic [OFF_W-1:0]  key_off;
    logic [SIZE_W-1:0] key_size;
    int unsigned       run_start;
    int unsigned       run_end;
    int unsigned       nxt_start;
    int unsigned       nxt_end;
    int                j;
    if (held_off.size() == 0) begin
      push_merged(0, 0, 1'b1, 1'b1);
      return;
    end
    srt_off  = held_off;
    srt_size = held_size;
    for (int i = 1; i < srt_off.size(); i++) begin
      key_off  = srt_off[i];
      key_size = srt_size[i];
      j = i;
      while (j > 0 && srt_off[j-1] > key_off) begin
        srt_off[j]  = srt_off[j-1];
        srt_size[j] = srt_size[j-1];
        j--;
      end
      srt_off[j]  = key_off;
      srt_size[j] = key_size;
    end
    run_start = srt_off[0];
    run_end   = run_start + srt_size[0];
    for (int i = 1; i < srt_off.size(); i++) begin
      nxt_start = srt_off[i];
      nxt_end   = nxt_start + srt_size[i];
      if (nxt_start <= run_end) begin
        if (nxt_end > run_end) run_end = nxt_end;
      end else begin
        push_merged(run_start, run_end, 1'b0, 1'b0);
        run_start = nxt_start;
        run_end   = nxt_end;
      end
    end
    push_merged(run_start, run_end, 1'b0, 1'b1);
    held_off.delete();
    held_size.delete();
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one item from the falling edge, optionally after an idle burst, and
  // hold it until a rising edge sees ready. Valid stays high on return so the
  // next item can follow without a bubble.
  task automatic send_item(input logic act, input logic [OFF_W-1:0] off,
                           input logic [SIZE_W-1:0] sz);
    int gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.range_offset <= off;
    in_ch.range_size   <= sz;
    do @(posedge clk_i); while (!in_ch.ready);
    // Accepted at this edge: advance the model.
    if (act == ACT_FLUSH) merge_flush();
    else track_record(off, sz);
    items_sent++;
  endtask

  // Drop valid, wait for every owed range, then let the chain settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (merged_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready pattern and checking
  // --------------------------------------------------------------------------

  // Drive ready at each falling edge. A hold-off request parks ready low for
  // a long stretch; otherwise throttle in short random bursts while enabled.
  initial begin
    int hold_left;
    int stall_left;
    hold_left     = 0;
    stall_left    = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && hold_left == 0) begin
        hold_left    = HOLD_OFF_LEN;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0d cycles: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  // Compare each accepted result with the oldest owed merged range.
  initial begin
    merged_range_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (merged_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result off=%h size=%h",
                                    out_ch.merged_offset, out_ch.merged_size));
        end else begin
          want = merged_expected_q.pop_front();
          if (out_ch.merged_offset !== want.offset)
            report_mismatch($sformatf("merged_offset got %h want %h",
                                      out_ch.merged_offset, want.offset));
          if (out_ch.merged_size !== want.msize)
            report_mismatch($sformatf("merged_size got %h want %h",
                                      out_ch.merged_size, want.msize));
          if (out_ch.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %b want %b",
                                      out_ch.is_empty, want.is_empty));
          if (out_ch.is_last !== want.is_last)
            report_mismatch($sformatf("is_last got %b want %b",
                                      out_ch.is_last, want.is_last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Flush straight after reset: one result flagged empty and last.
  task automatic test_empty_flush();
    send_item(ACT_FLUSH, 16'h0000, 16'h0000);
  endtask

  // A lone zero-length range comes back with size zero.
  task automatic test_zero_size();
    send_item(ACT_RECORD, 16'h0000, 16'h0000);
    send_item(ACT_FLUSH, 16'hFFFF, 16'hFFFF);
  endtask

  // Field extremes: a top range reaching past 16 bits, unioned with a full
  // range from zero, and alternating bit patterns on both fields.
  task automatic test_field_extremes();
    send_item(ACT_RECORD, 16'hFFFF, 16'hFFFF);
    send_item(ACT_RECORD, 16'h0000, 16'hFFFF);
    send_item(ACT_FLUSH, 16'h0000, 16'h0000);
    send_item(ACT_RECORD, 16'hAAAA, 16'h5555);
    send_item(ACT_RECORD, 16'h5555, 16'hAAAA);
    send_item(ACT_FLUSH, 16'hAAAA, 16'h5555);
  endtask

  // Touching ranges join, a zero-length range at the merged end joins, a
  // repeated offset only replaces its size, and a gap splits the output.
  task automatic test_touch_and_overwrite();
    send_item(ACT_RECORD, 16'd150, 16'd10);
    send_item(ACT_RECORD, 16'd100, 16'd50);
    send_item(ACT_RECORD, 16'd160, 16'd0);
    send_item(ACT_RECORD, 16'd300, 16'd10);
    send_item(ACT_RECORD, 16'd300, 16'd100);
    send_item(ACT_RECORD, 16'd1000, 16'd1);
    send_item(ACT_RECORD, 16'd402, 16'd0);
    send_item(ACT_FLUSH, 16'h5555, 16'hAAAA);
  endtask

  // Fill the table in descending order, overflow it, re-record a dropped
  // offset (still dropped) and a held one (size replaced), then flush.
  task automatic test_table_full();
    logic [OFF_W-1:0] offs[20];
    for (int i = 0; i < 20; i++) begin
      offs[i] = 16'hF000 - OFF_W'(i * 16'h0C00) + OFF_W'($urandom_range(0, 255));
      send_item(ACT_RECORD, offs[i], SIZE_W'($urandom_range(0, 16'h0D00)));
    end
    send_item(ACT_RECORD, offs[19], 16'd5);
    send_item(ACT_RECORD, offs[0], 16'h2000);
    send_item(ACT_FLUSH, 16'($urandom), 16'($urandom));
  endtask

  // One batch of records followed by a flush. Clustered batches land in a
  // narrow window so ranges overlap often; some offsets repeat on purpose.
  task automatic send_range_batch(input int n_rec, input bit clustered);
    logic [OFF_W-1:0]  base;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  used[$];
    logic [SIZE_W-1:0] sz;
    base = OFF_W'($urandom);
    for (int i = 0; i < n_rec; i++) begin
      if (used.size() != 0 && $urandom_range(0, 4) == 0)
        off = used[$urandom_range(0, used.size() - 1)];
      else if (clustered)
        off = base + OFF_W'($urandom_range(0, 511));
      else
        off = OFF_W'($urandom);
      sz = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom)
                                       : SIZE_W'($urandom_range(0, 96));
      used.push_back(off);
      send_item(ACT_RECORD, off, sz);
    end
    send_item(ACT_FLUSH, OFF_W'($urandom), SIZE_W'($urandom));
    // Now and then flush again on the cleared table.
    if ($urandom_range(0, 7) == 0)
      send_item(ACT_FLUSH, OFF_W'($urandom), SIZE_W'($urandom));
  endtask

  // Park the result side for a long stretch while batches keep coming, so
  // the output register fills and the block stops taking items.
  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    repeat (3) send_range_batch(4, 1'b1);
  endtask

  // Random batches up to a given item count. Batch sizes mostly stay under
  // the table depth, sometimes overflow it, and zero gives an empty flush.
  task automatic test_random_traffic(input int item_goal, input bit toggle_idle);
    int n_rec;
    while (items_sent < item_goal) begin
      if (toggle_idle && $urandom_range(0, 9) == 0) idle_en = ~idle_en;
      n_rec = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22)
                                          : $urandom_range(0, 12);
      send_range_batch(n_rec, $urandom_range(0, 4) != 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_RECORD;
    in_ch.range_offset = '0;
    in_ch.range_size   = '0;
    rst_ni             = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_flush();
    test_zero_size();
    test_field_extremes();
    test_touch_and_overwrite();
    test_table_full();
    test_output_hold_off();
    test_random_traffic(IDLE_PHASE_END, 1'b1);
    // Last stretch runs at full rate on both sides.
    idle_en = 1'b0;
    test_random_traffic(ITEM_TOTAL, 1'b0);

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("PASS dirty_range_tracker_merge");
    end else begin
      $display("FAIL dirty_range_tracker_merge");
    end
    $finish;
  end

endmodule

`default_nettype wire
